FILE: hw/rtl/erug_pkg.sv
// ----------------------------------------------------------------------------
// erug_pkg
// Shared types, constants and helpers of the echo residual upload gate.
// ----------------------------------------------------------------------------
package erug_pkg;

    // default sizes
    localparam int MAX_FRAME_SAMPLES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF       = 16;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;   // |sample|^2 up to 2^30
    localparam int RMS_W    = 15;
    localparam int RATIO_W  = 16;
    localparam int HANG_W   = 8;
    localparam int DELAY_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REF_PRESENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_RMS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIC_SQ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIC_REF_SQ  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_RMS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HANG_FRAMES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DELAY   = 3'd6;

    typedef enum logic [1:0] {
        REQ_CAPTURE = 2'd0,
        REQ_OUTPUT  = 2'd1,
        REQ_RESET   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        DEC_BYPASS   = 2'd0,
        DEC_NEAR     = 2'd1,
        DEC_SUPPRESS = 2'd2
    } t_dec;

    // classifier verdict
    typedef struct packed {
        logic empty;     // popped entry had no samples
        logic near_end;  // all three near-end tests passed
        logic suppress;  // reference energy at or above activity threshold
    } t_cls_res;

    // square of a signed PCM sample
    function automatic logic [SQ_W-1:0] sq16(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0]   mag;
        logic [2*SAMPLE_W-1:0] p;
        mag = v[SAMPLE_W-1] ? (~v + 1'b1) : v;
        p   = mag * mag;
        return p[SQ_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/erug_fifo_mem.sv
// ----------------------------------------------------------------------------
// erug_fifo_mem
// Metrics queue storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module erug_fifo_mem #(
    parameter int DEPTH = 16,
    parameter int DW    = 93
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/erug_classify.sv
// ----------------------------------------------------------------------------
// erug_classify
// Frame classifier: cross-multiplied threshold and ratio tests evaluated
// on one shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module erug_classify #(
    parameter int MAX_FRAME_SAMPLES = 1024
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_start,
    input  logic [2*(30+$clog2(MAX_FRAME_SAMPLES+1))
                  +$clog2(MAX_FRAME_SAMPLES+1)-1:0]       i_rdata,
    input  logic [30+$clog2(MAX_FRAME_SAMPLES+1)-1:0]     i_out_energy,
    input  logic [$clog2(MAX_FRAME_SAMPLES+1)-1:0]        i_out_count,
    input  logic [erug_pkg::RMS_W-1:0]                    i_near_rms,
    input  logic [erug_pkg::RATIO_W-1:0]                  i_out_mic_sq,
    input  logic [erug_pkg::RATIO_W-1:0]                  i_mic_ref_sq,
    input  logic [erug_pkg::RMS_W-1:0]                    i_ref_rms,
    output logic                                          o_done,
    output erug_pkg::t_cls_res                            o_res
);
    import erug_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int EW = 30 + CW;
    localparam int DW = 2 * EW + CW;
    localparam int PW = EW + CW;        // multiplier A operand
    localparam int LW = PW + RATIO_W;   // product / compare width
    localparam int TW = 2 * RMS_W;      // squared threshold

    typedef enum logic [9:0] {
        C_IDLE = 10'b0000000001,
        C_LOAD = 10'b0000000010,
        C_T2N  = 10'b0000000100,
        C_A2   = 10'b0000001000,
        C_A2N  = 10'b0000010000,
        C_EON  = 10'b0000100000,
        C_EMK  = 10'b0001000000,
        C_EMKR = 10'b0010000000,
        C_ERM  = 10'b0100000000,
        C_FIN  = 10'b1000000000
    } t_cstate;

    t_cstate r_state, n_state;
    logic    r_done,  n_done;

    logic [EW-1:0] r_em, n_em;
    logic [EW-1:0] r_er, n_er;
    logic [CW-1:0] r_n,  n_n;
    logic [TW-1:0] r_sq, n_sq;
    logic [LW-1:0] r_p,  n_p;
    logic [LW-1:0] r_lhs, n_lhs;
    logic          r_c1, n_c1;   // mic above near-end level
    logic          r_c2, n_c2;   // output/mic ratio
    logic          r_c4, n_c4;   // reference active
    t_cls_res      r_res, n_res;

    logic [PW-1:0]      w_mul_a;
    logic [RATIO_W-1:0] w_mul_b;
    logic [LW-1:0]      w_prod;
    logic [LW-1:0]      w_em_sh;

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_em_sh = LW'({r_em, 8'b0});

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_em    = r_em;
        n_er    = r_er;
        n_n     = r_n;
        n_sq    = r_sq;
        n_p     = r_p;
        n_lhs   = r_lhs;
        n_c1    = r_c1;
        n_c2    = r_c2;
        n_c4    = r_c4;
        n_res   = r_res;
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_state = C_LOAD;
                end
            end
            C_LOAD: begin
                n_em    = i_rdata[DW-1 -: EW];
                n_er    = i_rdata[CW +: EW];
                n_n     = i_rdata[CW-1:0];
                w_mul_a = PW'(i_near_rms);
                w_mul_b = RATIO_W'(i_near_rms);
                n_sq    = w_prod[TW-1:0];
                n_state = C_T2N;
            end
            C_T2N: begin
                w_mul_a = PW'(r_sq);
                w_mul_b = RATIO_W'(r_n);
                n_p     = w_prod;
                n_state = C_A2;
            end
            C_A2: begin
                n_c1    = (LW'(r_em) >= r_p);
                w_mul_a = PW'(i_ref_rms);
                w_mul_b = RATIO_W'(i_ref_rms);
                n_sq    = w_prod[TW-1:0];
                n_state = C_A2N;
            end
            C_A2N: begin
                w_mul_a = PW'(r_sq);
                w_mul_b = RATIO_W'(r_n);
                n_p     = w_prod;
                n_state = C_EON;
            end
            C_EON: begin
                n_c4    = (LW'(r_er) >= r_p);
                w_mul_a = PW'(i_out_energy);
                w_mul_b = RATIO_W'(r_n);
                n_p     = w_prod;
                n_state = C_EMK;
            end
            C_EMK: begin
                n_lhs   = {r_p[LW-9:0], 8'b0};   // Eo*n*256
                w_mul_a = PW'(r_em);
                w_mul_b = RATIO_W'(i_out_count);
                n_p     = w_prod;
                n_state = C_EMKR;
            end
            C_EMKR: begin
                w_mul_a = r_p[PW-1:0];
                w_mul_b = i_out_mic_sq;
                n_p     = w_prod;
                n_state = C_ERM;
            end
            C_ERM: begin
                n_c2    = (r_lhs >= r_p);
                w_mul_a = PW'(r_er);
                w_mul_b = i_mic_ref_sq;
                n_p     = w_prod;
                n_state = C_FIN;
            end
            C_FIN: begin
                n_res.empty    = (r_n == '0);
                n_res.near_end = r_c1 && r_c2 && (w_em_sh >= r_p);
                n_res.suppress = r_c4;
                n_done         = 1'b1;
                n_state        = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_em  <= n_em;
        r_er  <= n_er;
        r_n   <= n_n;
        r_sq  <= n_sq;
        r_p   <= n_p;
        r_lhs <= n_lhs;
        r_c1  <= n_c1;
        r_c2  <= n_c2;
        r_c4  <= n_c4;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hw/rtl/echo_residual_upload_gate_top.sv
// ----------------------------------------------------------------------------
// echo_residual_upload_gate_top
// Echo residual upload gate: frame energy accumulation, capture metrics
// queue and per-output-frame bypass / near-end / suppress decision.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | sink      | i_in_valid / o_in_stall  | req_type, mic/ref/out sample,
//          |           |                          | frame_last
//  out     | source    | o_out_valid / i_out_stall| decision, metrics_dropped
//  cfg     | sink      | i_cfg_we                 | i_cfg_idx, i_cfg_data
//
//  One item is in work at a time. A sample item passes register, square and
//  accumulate steps before the next transfer.
//  An output frame end that pops the queue adds a queue read and the steps on
//  the shared classifier multiplier, then a step to load the result.
//  Result loading waits while the output register holds an untaken result.
//  Reset (synchronous, active low) clears control, accumulators and config,
//  but sets ref_present; queue entries are not cleared, only read when occupied.
// ----------------------------------------------------------------------------
module echo_residual_upload_gate_top #(
    parameter int MAX_FRAME_SAMPLES = erug_pkg::MAX_FRAME_SAMPLES_DEF,
    parameter int QUEUE_DEPTH       = erug_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic signed [erug_pkg::SAMPLE_W-1:0] i_mic_sample,
    input  logic signed [erug_pkg::SAMPLE_W-1:0] i_ref_sample,
    input  logic signed [erug_pkg::SAMPLE_W-1:0] i_out_sample,
    input  logic                              i_frame_last,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_decision,
    output logic                              o_metrics_dropped,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [erug_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [erug_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import erug_pkg::*;

    localparam int CW  = $clog2(MAX_FRAME_SAMPLES + 1);   // sample count
    localparam int EW  = 30 + CW;                         // frame energy
    localparam int DW  = 2 * EW + CW;                     // queue entry
    localparam int AW  = $clog2(QUEUE_DEPTH);             // queue address
    localparam int OW  = $clog2(QUEUE_DEPTH + 1);         // occupancy
    localparam int DLW = (OW > DELAY_W) ? OW : DELAY_W;   // delay compare

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // ready for a transfer
        S_SQ   = 5'b00010,   // square the samples
        S_ACC  = 5'b00100,   // accumulate, push or start decision
        S_CLS  = 5'b01000,   // classifier running
        S_RES  = 5'b10000    // hand result to output register
    } t_state;

    t_state r_state, n_state;

    // captured item
    logic [1:0]          r_req;
    logic [SAMPLE_W-1:0] r_mic_s, r_ref_s, r_out_s;
    logic                r_last;
    logic [SQ_W-1:0]     r_sq_a, n_sq_a;   // mic or output sample square
    logic [SQ_W-1:0]     r_sq_b, n_sq_b;   // reference sample square

    // frame accumulators
    logic [EW-1:0] r_mic_acc, n_mic_acc;
    logic [EW-1:0] r_ref_acc, n_ref_acc;
    logic [CW-1:0] r_cap_cnt, n_cap_cnt;
    logic [EW-1:0] r_out_acc, n_out_acc;
    logic [CW-1:0] r_out_cnt, n_out_cnt;

    // queue control
    logic [OW-1:0] r_occ,    n_occ;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [HANG_W-1:0] r_hang, n_hang;
    logic          r_dropped, n_dropped;
    t_dec          r_dec, n_dec;

    // configuration
    logic                r_ref_present, n_ref_present;
    logic [RMS_W-1:0]    r_near_rms,    n_near_rms;
    logic [RATIO_W-1:0]  r_out_mic_sq,  n_out_mic_sq;
    logic [RATIO_W-1:0]  r_mic_ref_sq,  n_mic_ref_sq;
    logic [RMS_W-1:0]    r_ref_rms,     n_ref_rms;
    logic [HANG_W-1:0]   r_hang_frames, n_hang_frames;
    logic [DELAY_W-1:0]  r_delay,       n_delay;

    // output register
    logic r_out_valid, n_out_valid;
    t_dec r_out_dec,   n_out_dec;
    logic r_out_drop,  n_out_drop;

    // queue / classifier hookup
    logic          w_we, w_re, w_cls_start, w_cls_done;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata, w_rdata;
    logic [OW:0]   w_wsum;
    t_cls_res      w_cls_res;

    // accumulate step values
    logic          w_cap_room, w_out_room;
    logic [EW-1:0] w_mic_nxt, w_ref_nxt, w_out_nxt;
    logic [CW-1:0] w_cap_nxt, w_out_cnt_nxt;
    logic          w_pop_ok;

    assign w_cap_room    = (r_cap_cnt < CW'(MAX_FRAME_SAMPLES));
    assign w_out_room    = (r_out_cnt < CW'(MAX_FRAME_SAMPLES));
    assign w_mic_nxt     = w_cap_room ? (r_mic_acc + EW'(r_sq_a)) : r_mic_acc;
    assign w_ref_nxt     = w_cap_room ? (r_ref_acc + EW'(r_sq_b)) : r_ref_acc;
    assign w_cap_nxt     = w_cap_room ? (r_cap_cnt + 1'b1) : r_cap_cnt;
    assign w_out_nxt     = w_out_room ? (r_out_acc + EW'(r_sq_a)) : r_out_acc;
    assign w_out_cnt_nxt = w_out_room ? (r_out_cnt + 1'b1) : r_out_cnt;

    // write slot = read pointer + occupancy, wrapped at the queue depth
    assign w_wsum  = (OW+1)'(r_rd_ptr) + (OW+1)'(r_occ);
    assign w_waddr = (w_wsum >= (OW+1)'(QUEUE_DEPTH)) ?
                     AW'(w_wsum - (OW+1)'(QUEUE_DEPTH)) : AW'(w_wsum);
    assign w_wdata = {w_mic_nxt, w_ref_nxt, w_cap_nxt};

    // a pop needs a reference path and more entries than the set delay
    assign w_pop_ok = r_ref_present && (DLW'(r_occ) > DLW'(r_delay));

    always_comb begin
        n_state       = r_state;
        n_sq_a        = r_sq_a;
        n_sq_b        = r_sq_b;
        n_mic_acc     = r_mic_acc;
        n_ref_acc     = r_ref_acc;
        n_cap_cnt     = r_cap_cnt;
        n_out_acc     = r_out_acc;
        n_out_cnt     = r_out_cnt;
        n_occ         = r_occ;
        n_rd_ptr      = r_rd_ptr;
        n_hang        = r_hang;
        n_dropped     = r_dropped;
        n_dec         = r_dec;
        n_out_dec     = r_out_dec;
        n_out_drop    = r_out_drop;
        n_out_valid   = r_out_valid && i_out_stall;
        w_we          = 1'b0;
        w_re          = 1'b0;
        w_cls_start   = 1'b0;

        n_ref_present = r_ref_present;
        n_near_rms    = r_near_rms;
        n_out_mic_sq  = r_out_mic_sq;
        n_mic_ref_sq  = r_mic_ref_sq;
        n_ref_rms     = r_ref_rms;
        n_hang_frames = r_hang_frames;
        n_delay       = r_delay;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REF_PRESENT: n_ref_present = i_cfg_data[0];
                CFG_NEAR_RMS:    n_near_rms    = i_cfg_data[RMS_W-1:0];
                CFG_OUT_MIC_SQ:  n_out_mic_sq  = i_cfg_data[RATIO_W-1:0];
                CFG_MIC_REF_SQ:  n_mic_ref_sq  = i_cfg_data[RATIO_W-1:0];
                CFG_REF_RMS:     n_ref_rms     = i_cfg_data[RMS_W-1:0];
                CFG_HANG_FRAMES: n_hang_frames = i_cfg_data[HANG_W-1:0];
                CFG_OUT_DELAY:   n_delay       = i_cfg_data[DELAY_W-1:0];
                default: ;   // writes past the register list are ignored
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                // output items share the mic squarer lane
                n_sq_a  = sq16((t_req'(r_req) == REQ_OUTPUT) ? r_out_s : r_mic_s);
                n_sq_b  = sq16(r_ref_s);
                n_state = S_ACC;
            end
            S_ACC: begin
                n_state = S_IDLE;
                unique case (t_req'(r_req))
                    REQ_CAPTURE: begin
                        if (r_ref_present) begin
                            n_mic_acc = w_mic_nxt;
                            n_ref_acc = w_ref_nxt;
                            n_cap_cnt = w_cap_nxt;
                            if (r_last) begin
                                if (r_occ < OW'(QUEUE_DEPTH)) begin
                                    w_we  = 1'b1;
                                    n_occ = r_occ + 1'b1;
                                end else begin
                                    n_dropped = 1'b1;
                                end
                                n_mic_acc = '0;
                                n_ref_acc = '0;
                                n_cap_cnt = '0;
                            end
                        end
                    end
                    REQ_OUTPUT: begin
                        n_out_acc = w_out_nxt;
                        n_out_cnt = w_out_cnt_nxt;
                        if (r_last) begin
                            if (w_pop_ok) begin
                                w_re        = 1'b1;
                                w_cls_start = 1'b1;
                                n_rd_ptr    = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ?
                                              '0 : (r_rd_ptr + 1'b1);
                                n_occ       = r_occ - 1'b1;
                                n_state     = S_CLS;
                            end else begin
                                n_dec   = DEC_BYPASS;
                                n_state = S_RES;
                            end
                        end
                    end
                    REQ_RESET: begin
                        n_occ     = '0;
                        n_rd_ptr  = '0;
                        n_hang    = '0;
                        n_mic_acc = '0;
                        n_ref_acc = '0;
                        n_cap_cnt = '0;
                        n_out_acc = '0;
                        n_out_cnt = '0;
                    end
                    default: ;   // unused request code
                endcase
            end
            S_CLS: begin
                if (w_cls_done) begin
                    n_state = S_RES;
                    priority if (w_cls_res.empty) begin
                        n_dec = DEC_BYPASS;
                    end else if (w_cls_res.near_end) begin
                        n_hang = r_hang_frames;
                        n_dec  = DEC_NEAR;
                    end else if (r_hang != '0) begin
                        n_hang = r_hang - 1'b1;
                        n_dec  = DEC_NEAR;
                    end else if (w_cls_res.suppress) begin
                        n_dec = DEC_SUPPRESS;
                    end else begin
                        n_dec = DEC_BYPASS;
                    end
                end
            end
            S_RES: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_dec   = r_dec;
                    n_out_drop  = r_dropped;
                    n_dropped   = 1'b0;
                    n_out_acc   = '0;
                    n_out_cnt   = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mic_acc     <= '0;
            r_ref_acc     <= '0;
            r_cap_cnt     <= '0;
            r_out_acc     <= '0;
            r_out_cnt     <= '0;
            r_occ         <= '0;
            r_rd_ptr      <= '0;
            r_hang        <= '0;
            r_dropped     <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ref_present <= 1'b1;
            r_near_rms    <= '0;
            r_out_mic_sq  <= '0;
            r_mic_ref_sq  <= '0;
            r_ref_rms     <= '0;
            r_hang_frames <= '0;
            r_delay       <= '0;
        end else begin
            r_state       <= n_state;
            r_mic_acc     <= n_mic_acc;
            r_ref_acc     <= n_ref_acc;
            r_cap_cnt     <= n_cap_cnt;
            r_out_acc     <= n_out_acc;
            r_out_cnt     <= n_out_cnt;
            r_occ         <= n_occ;
            r_rd_ptr      <= n_rd_ptr;
            r_hang        <= n_hang;
            r_dropped     <= n_dropped;
            r_out_valid   <= n_out_valid;
            r_ref_present <= n_ref_present;
            r_near_rms    <= n_near_rms;
            r_out_mic_sq  <= n_out_mic_sq;
            r_mic_ref_sq  <= n_mic_ref_sq;
            r_ref_rms     <= n_ref_rms;
            r_hang_frames <= n_hang_frames;
            r_delay       <= n_delay;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_req   <= i_req_type;
            r_mic_s <= i_mic_sample;
            r_ref_s <= i_ref_sample;
            r_out_s <= i_out_sample;
            r_last  <= i_frame_last;
        end
        r_sq_a     <= n_sq_a;
        r_sq_b     <= n_sq_b;
        r_dec      <= n_dec;
        r_out_dec  <= n_out_dec;
        r_out_drop <= n_out_drop;
    end

    erug_fifo_mem #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (DW)
    ) u_fifo_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rdata)
    );

    erug_classify #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_classify (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_cls_start),
        .i_rdata      (w_rdata),
        .i_out_energy (r_out_acc),
        .i_out_count  (r_out_cnt),
        .i_near_rms   (r_near_rms),
        .i_out_mic_sq (r_out_mic_sq),
        .i_mic_ref_sq (r_mic_ref_sq),
        .i_ref_rms    (r_ref_rms),
        .o_done       (w_cls_done),
        .o_res        (w_cls_res)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_decision        = r_out_dec;
    assign o_metrics_dropped = r_out_drop;

endmodule
